@@ hw/rtl/btff_pkg.sv @@
// shared types, constants and codes for the boundary-tag first-fit allocator
`timescale 1ns / 1ps
`default_nettype none
package btff_pkg;

    // default heap size in bytes
    localparam int HEAP_BYTES_DEF = 1024;

    // field widths
    localparam int ARITH_W  = 30;   // datapath width of the shared unit
    localparam int LEN_W    = 29;   // block length field of a tag
    localparam int SIZE_W   = 11;   // request_size
    localparam int OFFS_W   = 10;   // payload_offset and address

    // allocate pads the size by 7 to round up to 8, then adds 8 for the tags
    localparam logic [ARITH_W-1:0] NEED_PAD = ARITH_W'(15);

    // request codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    // one boundary tag
    typedef struct packed {
        logic             alloc;
        logic [LEN_W-1:0] len;
    } t_tag;

    // shared add / subtract unit
    typedef struct packed {
        logic               sub;
        logic [ARITH_W-1:0] a;
        logic [ARITH_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ARITH_W-1:0] res;
        logic               lt;     // a < b, valid on subtract
        logic               zero;
    } t_alu_rsp;

    // tag memory strobes
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_en;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_INIT_HDR,
        S_INIT_FTR,
        S_IDLE,
        S_A_PRE,
        S_A_EVAL,
        S_A_NEXT,
        S_A_XF1,
        S_A_XF2,
        S_A_XF3,
        S_S1,
        S_S2,
        S_S3,
        S_S4,
        S_S5,
        S_F_CHK,
        S_F_CLEN,
        S_F_PF,
        S_F_PH,
        S_F_FT1,
        S_F_FT2,
        S_F_CA,
        S_F_CA2,
        S_F_CB,
        S_F_CC,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/boundary_tag_first_fit_allocator_core.sv @@
// top level of the boundary-tag first-fit heap allocator
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  request  | in        | i_valid / o_ready  | i_mode, i_request_size, i_payload_offset
//  result   | out       | o_valid / i_ready  | o_status, o_address
//
// after reset a clearing pass writes every tag slot with o_ready low. one request at a
// time: an allocate reads and compares one header after another until a fit or out
// of memory; a fit ends the walk at its header and goes on to an exact-fit footer
// update or a split; free runs serial read-modify-writes on the single tag memory.
// a result waits in the output register; the next request is taken while it stalls,
// and its own result waits until the register empties.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_first_fit_allocator_core #(
    parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_mode,
    input  wire [btff_pkg::SIZE_W-1:0]   i_request_size,
    input  wire [btff_pkg::OFFS_W-1:0]   i_payload_offset,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_status,
    output logic [btff_pkg::OFFS_W-1:0]  o_address
);
    import btff_pkg::*;

    localparam int TAG_WORDS = HEAP_BYTES / 4;
    localparam int AW        = $clog2(TAG_WORDS);

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    t_mem_en           mem_en;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    t_tag              wdata;
    t_tag              rdata;

    // sequencer
    btff_ctrl #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_request_size   (i_request_size),
        .i_payload_offset (i_payload_offset),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_address        (o_address),
        .o_alu_req        (alu_req),
        .i_alu_rsp        (alu_rsp),
        .o_mem_en         (mem_en),
        .o_raddr          (raddr),
        .o_waddr          (waddr),
        .o_wdata          (wdata),
        .i_rdata          (rdata)
    );

    // shared arithmetic
    btff_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // tag store
    btff_tag_ram #(
        .DEPTH (TAG_WORDS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_raddr (raddr),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/btff_alu.sv @@
// shared add / subtract / compare unit used by the sequencer
`timescale 1ns / 1ps
`default_nettype none
module btff_alu (
    input  wire btff_pkg::t_alu_req i_req,
    output btff_pkg::t_alu_rsp      o_rsp
);
    import btff_pkg::*;

    logic [ARITH_W:0] sum;

    // a + b, or a + ~b + 1 for subtract; carry out low means borrow
    assign sum = {1'b0, i_req.a}
               + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
               + (ARITH_W+1)'(i_req.sub);

    assign o_rsp.res  = sum[ARITH_W-1:0];
    assign o_rsp.lt   = i_req.sub & ~sum[ARITH_W];
    assign o_rsp.zero = (sum[ARITH_W-1:0] == '0);

endmodule
`default_nettype wire

@@ hw/rtl/btff_tag_ram.sv @@
// tag store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module btff_tag_ram #(
    parameter  int DEPTH = btff_pkg::HEAP_BYTES_DEF / 4,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire                    i_clk,
    input  wire btff_pkg::t_mem_en i_en,
    input  wire [AW-1:0]           i_raddr,
    input  wire [AW-1:0]           i_waddr,
    input  wire btff_pkg::t_tag    i_wdata,
    output btff_pkg::t_tag         o_rdata
);
    import btff_pkg::*;

    t_tag mem [DEPTH];
    t_tag r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_en.wr) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_en.rd) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/btff_ctrl.sv @@
// sequencer: clearing pass, first-fit walk, split, free and merge, result register
`timescale 1ns / 1ps
`default_nettype none
module btff_ctrl #(
    parameter  int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEF,
    localparam int TAG_WORDS  = HEAP_BYTES / 4,
    localparam int AW         = $clog2(TAG_WORDS)
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request channel
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire                               i_mode,
    input  wire [btff_pkg::SIZE_W-1:0]        i_request_size,
    input  wire [btff_pkg::OFFS_W-1:0]        i_payload_offset,
    // result channel
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic                              o_status,
    output logic [btff_pkg::OFFS_W-1:0]       o_address,
    // shared unit
    output btff_pkg::t_alu_req                o_alu_req,
    input  wire btff_pkg::t_alu_rsp           i_alu_rsp,
    // tag memory
    output btff_pkg::t_mem_en                 o_mem_en,
    output logic [AW-1:0]                     o_raddr,
    output logic [AW-1:0]                     o_waddr,
    output btff_pkg::t_tag                    o_wdata,
    input  wire btff_pkg::t_tag               i_rdata
);
    import btff_pkg::*;

    localparam logic [ARITH_W-1:0] TW_W   = ARITH_W'(TAG_WORDS);
    localparam logic [ARITH_W-1:0] LAST_W = ARITH_W'(TAG_WORDS - 1);
    localparam logic [LEN_W-1:0]   HEAP_L = LEN_W'(HEAP_BYTES);

    t_state r_state, n_state;

    logic [ARITH_W-1:0] r_w, n_w;           // header walk position / clear counter
    logic [ARITH_W-1:0] r_need, n_need;     // rounded block size
    logic [ARITH_W-1:0] r_nw1, n_nw1;       // need in words minus one
    logic [LEN_W-1:0]   r_len, n_len;       // length of the visited block
    logic [ARITH_W-1:0] r_rem, n_rem;       // split remainder
    logic [ARITH_W-1:0] r_rh, n_rh;         // remainder header
    logic [ARITH_W-1:0] r_tmp, n_tmp;
    logic [ARITH_W-1:0] r_idx, n_idx;       // footer slot
    logic [ARITH_W-1:0] r_cur, n_cur;       // header of block being freed
    logic [ARITH_W-1:0] r_pf, n_pf;         // previous footer
    logic [ARITH_W-1:0] r_ph, n_ph;         // previous header
    logic [LEN_W-1:0]   r_clen, n_clen;
    logic [LEN_W-1:0]   r_merged, n_merged;
    logic               r_fskip, n_fskip;
    logic               r_status, n_status;
    logic [OFFS_W-1:0]  r_addr, n_addr;
    logic               r_ovalid, n_ovalid;
    logic               r_ostatus, n_ostatus;
    logic [OFFS_W-1:0]  r_oaddr, n_oaddr;

    logic               rd_want, wr_want;
    logic [ARITH_W-1:0] rd_wide, wr_wide;
    t_alu_rsp           alu;

    assign alu = i_alu_rsp;

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_w      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_w      <= n_w;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need    <= n_need;
        r_nw1     <= n_nw1;
        r_len     <= n_len;
        r_rem     <= n_rem;
        r_rh      <= n_rh;
        r_tmp     <= n_tmp;
        r_idx     <= n_idx;
        r_cur     <= n_cur;
        r_pf      <= n_pf;
        r_ph      <= n_ph;
        r_clen    <= n_clen;
        r_merged  <= n_merged;
        r_fskip   <= n_fskip;
        r_status  <= n_status;
        r_addr    <= n_addr;
        r_ostatus <= n_ostatus;
        r_oaddr   <= n_oaddr;
    end

    // next state, shared unit operands and memory strobes
    always_comb begin
        n_state   = r_state;
        n_w       = r_w;
        n_need    = r_need;
        n_nw1     = r_nw1;
        n_len     = r_len;
        n_rem     = r_rem;
        n_rh      = r_rh;
        n_tmp     = r_tmp;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_pf      = r_pf;
        n_ph      = r_ph;
        n_clen    = r_clen;
        n_merged  = r_merged;
        n_fskip   = r_fskip;
        n_status  = r_status;
        n_addr    = r_addr;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_oaddr   = r_oaddr;
        o_alu_req = '0;
        rd_want   = 1'b0;
        rd_wide   = '0;
        wr_want   = 1'b0;
        wr_wide   = '0;
        o_wdata   = '0;
        o_ready   = 1'b0;

        // result register drains on transfer
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // zero every tag after reset
            S_CLEAR: begin
                wr_want   = 1'b1;
                wr_wide   = r_w;
                o_alu_req = '{sub: 1'b0, a: r_w, b: ARITH_W'(1)};
                n_w       = alu.res;
                if (r_w == LAST_W) begin
                    n_state = S_INIT_HDR;
                end
            end
            S_INIT_HDR: begin
                wr_want = 1'b1;
                wr_wide = '0;
                o_wdata = '{alloc: 1'b0, len: HEAP_L};
                n_state = S_INIT_FTR;
            end
            S_INIT_FTR: begin
                wr_want = 1'b1;
                wr_wide = LAST_W;
                o_wdata = '{alloc: 1'b0, len: HEAP_L};
                n_state = S_IDLE;
            end

            // take a request; size rounding or header slot computed on the way in
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_mode == MODE_FREE) begin
                    o_alu_req = '{sub: 1'b1,
                                  a: ARITH_W'(i_payload_offset[OFFS_W-1:2]),
                                  b: ARITH_W'(1)};
                end else begin
                    o_alu_req = '{sub: 1'b0, a: ARITH_W'(i_request_size), b: NEED_PAD};
                end
                if (i_valid) begin
                    n_status = STATUS_OK;
                    n_addr   = '0;
                    n_need   = {alu.res[ARITH_W-1:3], 3'b000};
                    n_cur    = alu.res;
                    n_fskip  = (i_payload_offset[OFFS_W-1:2] == '0);
                    n_w      = '0;
                    n_state  = (i_mode == MODE_FREE) ? S_F_CHK : S_A_PRE;
                end
            end

            // allocate: walk headers first-fit
            S_A_PRE: begin
                o_alu_req = '{sub: 1'b1, a: ARITH_W'(r_need[ARITH_W-1:2]), b: ARITH_W'(1)};
                n_nw1     = alu.res;
                rd_want   = 1'b1;
                rd_wide   = r_w;
                n_state   = S_A_EVAL;
            end
            S_A_EVAL: begin
                o_alu_req = '{sub: 1'b1, a: ARITH_W'(i_rdata.len), b: r_need};
                n_len     = i_rdata.len;
                n_rem     = alu.res;
                if (!i_rdata.alloc && alu.zero) begin
                    wr_want = 1'b1;
                    wr_wide = r_w;
                    o_wdata = '{alloc: 1'b1, len: i_rdata.len};
                    n_state = S_A_XF1;
                end else if (!i_rdata.alloc && !alu.lt) begin
                    n_state = S_S1;
                end else begin
                    n_state = S_A_NEXT;
                end
            end
            S_A_NEXT: begin
                o_alu_req = '{sub: 1'b0, a: r_w, b: ARITH_W'(r_len[LEN_W-1:2])};
                if (r_len[LEN_W-1:2] == '0 || alu.res >= TW_W) begin
                    n_status = STATUS_OOM;
                    n_addr   = '0;
                    n_state  = S_RESP;
                end else begin
                    n_w     = alu.res;
                    rd_want = 1'b1;
                    rd_wide = alu.res;
                    n_state = S_A_EVAL;
                end
            end

            // exact fit: mark the footer too
            S_A_XF1: begin
                o_alu_req = '{sub: 1'b0, a: r_w, b: r_nw1};
                n_idx     = alu.res;
                n_state   = S_A_XF2;
            end
            S_A_XF2: begin
                o_alu_req = '{sub: 1'b0, a: r_w, b: ARITH_W'(1)};
                n_addr    = {alu.res[OFFS_W-3:0], 2'b00};
                if (r_idx < TW_W) begin
                    rd_want = 1'b1;
                    rd_wide = r_idx;
                    n_state = S_A_XF3;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_A_XF3: begin
                wr_want = 1'b1;
                wr_wide = r_idx;
                o_wdata = '{alloc: 1'b1, len: i_rdata.len};
                n_state = S_RESP;
            end

            // split: free remainder tags, then allocated front tags
            S_S1: begin
                o_alu_req = '{sub: 1'b0, a: r_w, b: ARITH_W'(r_need[ARITH_W-1:2])};
                n_rh      = alu.res;
                n_state   = S_S2;
            end
            S_S2: begin
                wr_want   = 1'b1;
                wr_wide   = r_rh;
                o_wdata   = '{alloc: 1'b0, len: r_rem[LEN_W-1:0]};
                o_alu_req = '{sub: 1'b1, a: ARITH_W'(r_rem[ARITH_W-1:2]), b: ARITH_W'(1)};
                // short remainder keeps its footer on the header slot
                n_tmp     = (r_rem[ARITH_W-1:2] == '0) ? '0 : alu.res;
                n_state   = S_S3;
            end
            S_S3: begin
                o_alu_req = '{sub: 1'b0, a: r_rh, b: r_tmp};
                wr_want   = 1'b1;
                wr_wide   = alu.res;
                o_wdata   = '{alloc: 1'b0, len: r_rem[LEN_W-1:0]};
                n_state   = S_S4;
            end
            S_S4: begin
                wr_want   = 1'b1;
                wr_wide   = r_w;
                o_wdata   = '{alloc: 1'b1, len: r_need[LEN_W-1:0]};
                o_alu_req = '{sub: 1'b0, a: r_w, b: r_nw1};
                n_idx     = alu.res;
                n_state   = S_S5;
            end
            S_S5: begin
                wr_want   = 1'b1;
                wr_wide   = r_idx;
                o_wdata   = '{alloc: 1'b1, len: r_need[LEN_W-1:0]};
                o_alu_req = '{sub: 1'b0, a: r_w, b: ARITH_W'(1)};
                n_addr    = {alu.res[OFFS_W-3:0], 2'b00};
                n_state   = S_RESP;
            end

            // free: read own header
            S_F_CHK: begin
                if (r_fskip || r_cur >= TW_W) begin
                    n_state = S_RESP;
                end else begin
                    rd_want = 1'b1;
                    rd_wide = r_cur;
                    n_state = S_F_CLEN;
                end
            end
            S_F_CLEN: begin
                n_clen    = i_rdata.len;
                o_alu_req = '{sub: 1'b1, a: r_cur, b: ARITH_W'(1)};
                n_pf      = alu.res;
                // heap start has no predecessor
                if (r_cur != '0) begin
                    rd_want = 1'b1;
                    rd_wide = alu.res;
                    n_state = S_F_PF;
                end else begin
                    n_state = S_F_CA;
                end
            end
            // previous footer: locate previous header if it is free and sane
            S_F_PF: begin
                o_alu_req = '{sub: 1'b1, a: r_cur, b: ARITH_W'(i_rdata.len[LEN_W-1:2])};
                n_ph      = alu.res;
                if (!i_rdata.alloc && i_rdata.len[LEN_W-1:2] != '0 && !alu.lt) begin
                    rd_want = 1'b1;
                    rd_wide = alu.res;
                    n_state = S_F_PH;
                end else begin
                    n_state = S_F_CA;
                end
            end
            S_F_PH: begin
                o_alu_req = '{sub: 1'b0, a: ARITH_W'(i_rdata.len), b: ARITH_W'(r_clen)};
                n_merged  = alu.res[LEN_W-1:0];
                wr_want   = 1'b1;
                wr_wide   = r_ph;
                o_wdata   = '{alloc: i_rdata.alloc, len: alu.res[LEN_W-1:0]};
                n_state   = (r_clen[LEN_W-1:2] != '0) ? S_F_FT1 : S_F_CA;
            end
            S_F_FT1: begin
                o_alu_req = '{sub: 1'b0, a: r_pf, b: ARITH_W'(r_clen[LEN_W-1:2])};
                n_idx     = alu.res;
                if (alu.res < TW_W) begin
                    rd_want = 1'b1;
                    rd_wide = alu.res;
                    n_state = S_F_FT2;
                end else begin
                    n_state = S_F_CA;
                end
            end
            S_F_FT2: begin
                wr_want = 1'b1;
                wr_wide = r_idx;
                o_wdata = '{alloc: i_rdata.alloc, len: r_merged};
                n_state = S_F_CA;
            end

            // clear allocated flags on header, then footer
            S_F_CA: begin
                rd_want   = 1'b1;
                rd_wide   = r_cur;
                o_alu_req = '{sub: 1'b1, a: ARITH_W'(r_clen), b: ARITH_W'(1)};
                n_tmp     = alu.res;
                n_state   = S_F_CA2;
            end
            S_F_CA2: begin
                wr_want   = 1'b1;
                wr_wide   = r_cur;
                o_wdata   = '{alloc: 1'b0, len: i_rdata.len};
                o_alu_req = '{sub: 1'b0, a: r_cur, b: ARITH_W'(r_tmp[ARITH_W-1:2])};
                n_idx     = alu.res;
                // zero-length block gets no footer update
                if (r_clen[LEN_W-1:2] != '0 && alu.res < TW_W) begin
                    n_state = S_F_CB;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_F_CB: begin
                rd_want = 1'b1;
                rd_wide = r_idx;
                n_state = S_F_CC;
            end
            S_F_CC: begin
                wr_want = 1'b1;
                wr_wide = r_idx;
                o_wdata = '{alloc: 1'b0, len: i_rdata.len};
                n_state = S_RESP;
            end

            // hand the result to the output register once it is free
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oaddr   = r_addr;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slots beyond the heap are neither read nor written
    assign o_mem_en.rd = rd_want && (rd_wide < TW_W);
    assign o_mem_en.wr = wr_want && (wr_wide < TW_W);
    assign o_raddr     = rd_wide[AW-1:0];
    assign o_waddr     = wr_wide[AW-1:0];

    assign o_valid   = r_ovalid;
    assign o_status  = r_ostatus;
    assign o_address = r_oaddr;

endmodule
`default_nettype wire
